/* rtl/core/fr_pkg.sv */
// fr_pkg: shared types and codes of the fragment reassembler.
// No dependencies; imported by every module under rtl/core.
package fr_pkg;

    // Host command codes carried in the cmd field
    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Frame header codes
    localparam logic [7:0] HDR_SINGLE = 8'h00;
    localparam logic [7:0] HDR_START  = 8'h01;
    localparam logic [7:0] HDR_MIDDLE = 8'h02;
    localparam logic [7:0] HDR_END    = 8'h03;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_HEADER,
        OP_PAYLOAD,
        OP_CLEAR,
        OP_READ,
        OP_NONE
    } fr_op_kind_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OVERFLOW,
        ST_UNEXPECTED
    } fr_status_t;

    // Decoded item as it travels from front to back
    typedef struct packed {
        fr_op_kind_t kind;
        logic [7:0]  data;
        logic        last;
        logic [7:0]  plen;
        logic [6:0]  read_index;
    } fr_op_t;

    // Result held in the back's output stage
    typedef struct packed {
        logic       msg_ready;
        logic [7:0] message_len;
        fr_status_t frame_status;
        logic       hit;
    } fr_res_t;

endpackage

/* rtl/core/fr_in_if.sv */
// fr_in_if: input beat channel of the fragment reassembler.
// Valid/ready handshake with the frame byte payload; no dependencies.
interface fr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] frame_len;
    logic [6:0] read_index;

    modport source (output valid, cmd, data_byte, first_byte, last_byte, frame_len,
                    read_index, input ready);
    modport sink (input valid, cmd, data_byte, first_byte, last_byte, frame_len,
                  read_index, output ready);
endinterface

/* rtl/core/fr_out_if.sv */
// fr_out_if: result beat channel of the fragment reassembler.
// Valid/ready handshake with the result payload; no dependencies.
interface fr_out_if;
    logic       valid;
    logic       ready;
    logic       msg_ready;
    logic [7:0] message_len;
    logic [7:0] read_data;
    logic [1:0] frame_status;

    modport source (output valid, msg_ready, message_len, read_data, frame_status,
                    input ready);
    modport sink (input valid, msg_ready, message_len, read_data, frame_status,
                  output ready);
endinterface

/* rtl/core/fr_front.sv */
// fr_front: accepts input beats and decodes them into queue ops.
// Depends on fr_pkg and fr_in_if.
module fr_front (
    fr_in_if.sink           item,
    input  logic            full,
    output logic            push,
    output fr_pkg::fr_op_t  op
);
    import fr_pkg::*;

    assign item.ready = !full;
    assign push       = item.valid && !full;

    always_comb
    begin
        op            = '0;
        op.data       = item.data_byte;
        op.read_index = item.read_index;
        // payload length wraps modulo 256, as does a frame_len of zero
        op.plen       = item.frame_len - 8'd1;
        op.last       = 1'b0;
        case (item.cmd)
            CMD_FRAME:
            begin
                op.kind = item.first_byte ? OP_HEADER : OP_PAYLOAD;
                op.last = item.last_byte;
            end
            CMD_CLEAR: op.kind = OP_CLEAR;
            CMD_READ:  op.kind = OP_READ;
            default:   op.kind = OP_NONE;
        endcase
    end

endmodule

/* rtl/core/fr_queue.sv */
// fr_queue: short op queue that decouples front and back.
// Depends on fr_pkg.
module fr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fr_pkg::fr_op_t  push_op,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output fr_pkg::fr_op_t  head_op
);
    import fr_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    fr_op_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("queue written while full");
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid) else $error("queue popped while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");
`endif

endmodule

/* rtl/core/fr_back.sv */
// fr_back: executes queued ops against the reassembly state and byte store.
// Depends on fr_pkg and fr_out_if.
module fr_back #(
    parameter int MSG_CAPACITY = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  fr_pkg::fr_op_t  head_op,
    output logic            pop,
    fr_out_if.source        result
);
    import fr_pkg::*;

    localparam int         AW   = (MSG_CAPACITY > 1) ? $clog2(MSG_CAPACITY) : 1;
    localparam logic [8:0] CAP9 = 9'(MSG_CAPACITY);

    logic [7:0] mem [MSG_CAPACITY];
    logic [7:0] mem_q_reg;

    logic       in_progress_reg, in_progress_next;
    logic [7:0] assembled_count_reg, assembled_count_next;
    logic [7:0] stored_len_reg, stored_len_next;
    logic       ready_flag_reg, ready_flag_next;
    logic [7:0] write_pos_reg, write_pos_next;
    logic       frame_accept_reg, frame_accept_next;
    logic       out_valid_reg, out_valid_next;
    fr_res_t    res_reg, res_next;

    logic       wr_en;
    logic [8:0] total;
    logic [7:0] ridx8;
    logic       fits_single;
    logic       fits_append;

    assign pop   = head_valid && (!out_valid_reg || result.ready);
    assign total = {1'b0, assembled_count_reg} + {1'b0, head_op.plen};
    assign ridx8 = {1'b0, head_op.read_index};
    assign fits_single = ({1'b0, head_op.plen} <= CAP9);
    assign fits_append = (total <= CAP9);

    always_comb
    begin
        in_progress_next     = in_progress_reg;
        assembled_count_next = assembled_count_reg;
        stored_len_next      = stored_len_reg;
        ready_flag_next      = ready_flag_reg;
        write_pos_next       = write_pos_reg;
        frame_accept_next    = frame_accept_reg;
        wr_en                = 1'b0;
        res_next             = '0;
        res_next.frame_status = ST_OK;

        case (head_op.kind)
            OP_HEADER:
            begin
                frame_accept_next = 1'b0;
                if (head_op.data == HDR_SINGLE)
                begin
                    if (fits_single)
                    begin
                        stored_len_next   = head_op.plen;
                        write_pos_next    = '0;
                        frame_accept_next = 1'b1;
                    end
                    else
                    begin
                        in_progress_next      = 1'b0;
                        assembled_count_next  = '0;
                        res_next.frame_status = ST_OVERFLOW;
                    end
                end
                else if (head_op.data == HDR_START)
                begin
                    if (fits_single)
                    begin
                        in_progress_next     = 1'b1;
                        assembled_count_next = head_op.plen;
                        write_pos_next       = '0;
                        frame_accept_next    = 1'b1;
                    end
                    else
                    begin
                        in_progress_next      = 1'b0;
                        assembled_count_next  = '0;
                        res_next.frame_status = ST_OVERFLOW;
                    end
                end
                else if ((head_op.data == HDR_MIDDLE || head_op.data == HDR_END)
                         && in_progress_reg)
                begin
                    if (fits_append)
                    begin
                        write_pos_next       = assembled_count_reg;
                        assembled_count_next = total[7:0];
                        frame_accept_next    = 1'b1;
                        if (head_op.data == HDR_END)
                        begin
                            stored_len_next  = total[7:0];
                            in_progress_next = 1'b0;
                        end
                    end
                    else
                    begin
                        in_progress_next      = 1'b0;
                        assembled_count_next  = '0;
                        res_next.frame_status = ST_OVERFLOW;
                    end
                end
                else
                begin
                    in_progress_next      = 1'b0;
                    assembled_count_next  = '0;
                    stored_len_next       = '0;
                    res_next.frame_status = ST_UNEXPECTED;
                end
            end
            OP_PAYLOAD:
            begin
                if (frame_accept_reg && ({1'b0, write_pos_reg} < CAP9))
                begin
                    wr_en          = 1'b1;
                    write_pos_next = write_pos_reg + 8'd1;
                end
            end
            OP_CLEAR:
            begin
                stored_len_next = '0;
                ready_flag_next = 1'b0;
            end
            OP_READ:
            begin
                res_next.hit = (ridx8 < stored_len_reg) && ({1'b0, ridx8} < CAP9);
            end
            default:
            begin
            end
        endcase

        // frame end: close the frame, then recompute ready from the updated state
        if (head_op.last)
        begin
            frame_accept_next = 1'b0;
            ready_flag_next   = !in_progress_next && (stored_len_next != '0);
        end

        res_next.msg_ready   = ready_flag_next;
        res_next.message_len = stored_len_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_progress_reg     <= 1'b0;
            assembled_count_reg <= '0;
            stored_len_reg      <= '0;
            ready_flag_reg      <= 1'b0;
            write_pos_reg       <= '0;
            frame_accept_reg    <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                in_progress_reg     <= in_progress_next;
                assembled_count_reg <= assembled_count_next;
                stored_len_reg      <= stored_len_next;
                ready_flag_reg      <= ready_flag_next;
                write_pos_reg       <= write_pos_next;
                frame_accept_reg    <= frame_accept_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    // byte store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (pop && wr_en)
        begin
            mem[write_pos_reg[AW-1:0]] <= head_op.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mem_q_reg <= mem[ridx8[AW-1:0]];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.msg_ready    = res_reg.msg_ready;
    assign result.message_len  = res_reg.message_len;
    assign result.frame_status = res_reg.frame_status;
    assign result.read_data    = res_reg.hit ? mem_q_reg : 8'd0;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, assembled_count_reg} <= CAP9) else $error("assembled count past capacity");
    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, stored_len_reg} <= CAP9) else $error("stored length past capacity");
    a_wpos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, write_pos_reg} <= CAP9) else $error("write position past capacity");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(res_reg)))
        else $error("result changed while stalled");
`endif

endmodule

/* rtl/core/fragment_reassembler.sv */
// fragment_reassembler: top level; rebuilds messages from frame byte beats.
// Depends on fr_pkg, fr_in_if, fr_out_if, fr_front, fr_queue, fr_back.
//
//  channel | dir  | beat contents
//  --------+------+-----------------------------------------------------------
//  item    | in   | cmd, data_byte, first_byte, last_byte, frame_len, read_index
//  result  | out  | msg_ready, message_len, read_data, frame_status
//
// One beat per cycle while result.ready is high; each item gives exactly one
// result beat. An accepted beat is written into the queue, executed at the
// queue head, and its result registered in the back's output stage (read
// data comes from the store's registered read port in the same stage).
// The two-entry queue between front and back keeps item.ready high while a
// result waits for result.ready; ready drops only when the queue is full.
// rst_n clears all control state asynchronously; the byte store is not
// cleared and needs no clearing pass, so beats are taken right after reset.
module fragment_reassembler #(
    parameter int MSG_CAPACITY = 128
) (
    input  logic     clk,
    input  logic     rst_n,
    fr_in_if.sink    item,
    fr_out_if.source result
);
    import fr_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_head_valid;
    fr_op_t q_push_op;
    fr_op_t q_head_op;

    // front: handshake and decode of the incoming beat
    fr_front u_front (
        .item (item),
        .full (q_full),
        .push (q_push),
        .op   (q_push_op)
    );

    // queue: decouples decode from execution
    fr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_push_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_op    (q_head_op)
    );

    // back: reassembly state, byte store and result stage
    fr_back #(
        .MSG_CAPACITY (MSG_CAPACITY)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_op    (q_head_op),
        .pop        (q_pop),
        .result     (result)
    );

endmodule
